[sv/usb_standard_request_handler_top_macros.svh]
// Assertion macros shared by the USB standard request handler top level.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef USB_STANDARD_REQUEST_HANDLER_TOP_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define USRH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define USRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/usrh_pkg.sv]
// Package for the USB standard request handler: payload structs, request keys,
// action and source codes, register indexes and small helpers. No dependencies.
`timescale 1ns / 1ps

package usrh_pkg;

    // Default endpoint count
    localparam int ENDPOINTS_DEF = 8;

    // Setup packet fields
    typedef struct packed {
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
    } t_in_item;

    // Response fields
    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  data_source;
        logic [2:0]  string_number;
        logic [15:0] send_length;
        logic [15:0] immediate_word;
        logic [6:0]  device_address;
        logic        address_enabled;
        logic        configured_event;
    } t_out_item;

    // Response actions
    typedef enum logic [1:0] {
        ACT_STALL = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_ZLP   = 2'd2
    } t_action;

    // Data sources for a send
    typedef enum logic [2:0] {
        SRC_DEVICE  = 3'd0,
        SRC_CONFIG  = 3'd1,
        SRC_STR0    = 3'd2,
        SRC_STRN    = 3'd3,
        SRC_CFGBYTE = 3'd4,
        SRC_STATUS  = 3'd5,
        SRC_REPORT  = 3'd6
    } t_source;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEVICE_DESC_LEN  = 3'd0,
        CFG_CONFIG_TOTAL_LEN = 3'd1,
        CFG_STRING_ZERO_LEN  = 3'd2,
        CFG_STRING_COUNT     = 3'd3,
        CFG_STRING_CHARS     = 3'd4,
        CFG_REPORT_DESC_LEN  = 3'd5,
        CFG_EP_ENABLE_MASK   = 3'd6
    } t_cfg_reg;

    // {bRequest, bmRequestType} keys
    localparam logic [15:0] KEY_GET_DESC         = 16'h0680;
    localparam logic [15:0] KEY_GET_DESC_IF      = 16'h0681;
    localparam logic [15:0] KEY_SET_ADDRESS      = 16'h0500;
    localparam logic [15:0] KEY_SET_CONFIG       = 16'h0900;
    localparam logic [15:0] KEY_GET_CONFIG       = 16'h0880;
    localparam logic [15:0] KEY_GET_STATUS_DEV   = 16'h0080;
    localparam logic [15:0] KEY_GET_STATUS_IF    = 16'h0081;
    localparam logic [15:0] KEY_GET_STATUS_EP    = 16'h0082;
    localparam logic [15:0] KEY_SET_FEATURE_IF   = 16'h0301;
    localparam logic [15:0] KEY_CLEAR_FEATURE_IF = 16'h0101;
    localparam logic [15:0] KEY_SET_FEATURE_EP   = 16'h0302;
    localparam logic [15:0] KEY_CLEAR_FEATURE_EP = 16'h0102;

    // Descriptor types in wValue high byte
    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    // String limits
    localparam logic [3:0] STRING_SLOTS     = 4'd8;
    localparam logic [7:0] STRING_CHARS_MAX = 8'd126;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the setup packet
        logic exec;   // decode, update state, write the response register
    } t_dp_cmd;

    // Smaller of two lengths
    function automatic logic [15:0] clip16(input logic [15:0] want,
                                           input logic [15:0] have);
        return (want < have) ? want : have;
    endfunction

endpackage

[sv/usrh_ctrl.sv]
// Controller for the USB standard request handler: input/output handshakes,
// sequencing of the datapath. Depends on usrh_pkg.
`timescale 1ns / 1ps

module usrh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output usrh_pkg::t_dp_cmd o_cmd
);
    import usrh_pkg::*;

    t_state r_state, n_state;
    logic   r_out_full, n_out_full;
    logic   can_write;

    // Response register free this cycle (empty, or being taken now)
    assign can_write = !r_out_full || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (can_write) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = can_write;
            end
            default: ;
        endcase
    end

    // Response register occupancy
    always_comb begin
        n_out_full = r_out_full;
        if (o_cmd.exec) n_out_full = 1'b1;
        else if (r_out_full && !i_out_stall) n_out_full = 1'b0;
    end

    assign o_out_valid = r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_out_full <= n_out_full;
        end
    end

endmodule

[sv/usrh_dp.sv]
// Datapath for the USB standard request handler: config registers, device
// state, request decode and response register. Depends on usrh_pkg.
`timescale 1ns / 1ps

module usrh_dp #(
    parameter int ENDPOINTS = usrh_pkg::ENDPOINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usrh_pkg::t_dp_cmd  i_cmd,
    input  usrh_pkg::t_in_item i_in_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output usrh_pkg::t_out_item o_out_data
);
    import usrh_pkg::*;

    localparam int EP_W = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;

    // Config registers
    logic [7:0]  r_device_desc_len;
    logic [15:0] r_config_total_len;
    logic [7:0]  r_string_zero_len;
    logic [3:0]  r_string_count;
    logic [63:0] r_string_chars;
    logic [15:0] r_report_desc_len;
    logic [15:0] r_ep_mask;

    // Device state
    logic [6:0] r_addr, n_addr;
    logic       r_addr_valid, n_addr_valid;
    logic [7:0] r_cur_cfg, n_cur_cfg;
    logic [1:0] r_ep_cfg [ENDPOINTS];
    logic [1:0] n_ep_cfg [ENDPOINTS];
    logic [1:0] r_ep_halt [ENDPOINTS];
    logic [1:0] n_ep_halt [ENDPOINTS];

    // Captured request and response
    t_in_item  r_req;
    t_out_item r_out, n_out;

    // Request fields
    logic [15:0]     key;
    logic [3:0]      ep;
    logic            dir;
    logic [EP_W-1:0] ep_sel;
    logic            ep_in_range;
    logic            ep_cfg_bit;
    logic            ep_feature_ok;
    logic [7:0]      dtype, didx;
    logic [3:0]      str_limit;
    logic [7:0]      chars;
    logic [6:0]      chars_sat;
    logic [7:0]      str_len;

    assign key    = {r_req.request_code, r_req.request_type};
    assign ep     = r_req.setup_index[3:0];
    assign dir    = r_req.setup_index[7];
    assign ep_sel = ep[EP_W-1:0];
    assign dtype  = r_req.setup_value[15:8];
    assign didx   = r_req.setup_value[7:0];

    // Endpoint lookup
    assign ep_in_range   = ({1'b0, ep} < 5'(ENDPOINTS));
    assign ep_cfg_bit    = ep_in_range && r_ep_cfg[ep_sel][dir];
    assign ep_feature_ok = (r_req.setup_value == 16'd0) && (ep != 4'd0) && ep_cfg_bit;

    // String descriptor length: 2 * saturated count + 2
    assign str_limit = (r_string_count > STRING_SLOTS) ? STRING_SLOTS : r_string_count;
    assign chars     = r_string_chars[{didx[2:0], 3'b000} +: 8];
    assign chars_sat = (chars > STRING_CHARS_MAX) ? STRING_CHARS_MAX[6:0] : chars[6:0];
    assign str_len   = {chars_sat, 1'b0} + 8'd2;

    // Request decode and state update
    always_comb begin
        n_addr       = r_addr;
        n_addr_valid = r_addr_valid;
        n_cur_cfg    = r_cur_cfg;
        n_ep_cfg     = r_ep_cfg;
        n_ep_halt    = r_ep_halt;
        n_out        = '0;
        n_out.action = ACT_STALL;

        unique case (key) inside
            KEY_GET_DESC: begin
                if (dtype == DESC_DEVICE) begin
                    n_out.action      = ACT_SEND;
                    n_out.data_source = SRC_DEVICE;
                    n_out.send_length = clip16(r_req.setup_length,
                                               {8'd0, r_device_desc_len});
                end else if (dtype == DESC_CONFIG) begin
                    n_out.action      = ACT_SEND;
                    n_out.data_source = SRC_CONFIG;
                    n_out.send_length = clip16(r_req.setup_length, r_config_total_len);
                end else if (dtype == DESC_STRING) begin
                    if (didx == 8'd0) begin
                        n_out.action      = ACT_SEND;
                        n_out.data_source = SRC_STR0;
                        n_out.send_length = clip16(r_req.setup_length,
                                                   {8'd0, r_string_zero_len});
                    end else if (didx < {4'd0, str_limit}) begin
                        n_out.action        = ACT_SEND;
                        n_out.data_source   = SRC_STRN;
                        n_out.string_number = didx[2:0];
                        n_out.send_length   = clip16(r_req.setup_length, {8'd0, str_len});
                    end
                end
            end
            KEY_SET_ADDRESS: begin
                n_out.action = ACT_ZLP;
                n_addr       = r_req.setup_value[6:0];
                n_addr_valid = 1'b1;
            end
            KEY_SET_CONFIG: begin
                n_out.action = ACT_ZLP;
                n_cur_cfg    = r_req.setup_value[7:0];
                if (r_req.setup_value[7:0] != 8'd0) begin
                    // endpoint 0 stays configured; mask covers endpoints 1..7
                    for (int e = 1; e < ENDPOINTS; e++) begin
                        if (e < 8) n_ep_cfg[e] = r_ep_cfg[e] | r_ep_mask[2*e +: 2];
                    end
                    n_out.configured_event = 1'b1;
                end
            end
            KEY_GET_CONFIG: begin
                n_out.action         = ACT_SEND;
                n_out.data_source    = SRC_CFGBYTE;
                n_out.send_length    = clip16(r_req.setup_length, 16'd1);
                n_out.immediate_word = {8'd0, r_cur_cfg};
            end
            KEY_GET_STATUS_DEV, KEY_GET_STATUS_IF: begin
                n_out.action      = ACT_SEND;
                n_out.data_source = SRC_STATUS;
                n_out.send_length = clip16(r_req.setup_length, 16'd2);
            end
            KEY_GET_STATUS_EP: begin
                if (ep_cfg_bit) begin
                    n_out.action         = ACT_SEND;
                    n_out.data_source    = SRC_STATUS;
                    n_out.send_length    = clip16(r_req.setup_length, 16'd2);
                    n_out.immediate_word = {15'd0, r_ep_halt[ep_sel][dir]};
                end
            end
            KEY_SET_FEATURE_IF, KEY_CLEAR_FEATURE_IF: begin
                n_out.action = ACT_ZLP;
            end
            KEY_SET_FEATURE_EP: begin
                if (ep_feature_ok) begin
                    n_ep_halt[ep_sel][dir] = 1'b1;
                    n_out.action           = ACT_ZLP;
                end
            end
            KEY_CLEAR_FEATURE_EP: begin
                if (ep_feature_ok) begin
                    n_ep_halt[ep_sel][dir] = 1'b0;
                    n_out.action           = ACT_ZLP;
                end
            end
            KEY_GET_DESC_IF: begin
                n_out.action      = ACT_SEND;
                n_out.data_source = SRC_REPORT;
                n_out.send_length = clip16(r_req.setup_length, r_report_desc_len);
            end
            default: ;
        endcase

        n_out.device_address  = n_addr;
        n_out.address_enabled = n_addr_valid;
    end

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_desc_len  <= 8'd18;
            r_config_total_len <= 16'd9;
            r_string_zero_len  <= 8'd4;
            r_string_count     <= 4'd1;
            r_string_chars     <= '0;
            r_report_desc_len  <= '0;
            r_ep_mask          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_DESC_LEN:  r_device_desc_len  <= i_cfg_data[7:0];
                CFG_CONFIG_TOTAL_LEN: r_config_total_len <= i_cfg_data[15:0];
                CFG_STRING_ZERO_LEN:  r_string_zero_len  <= i_cfg_data[7:0];
                CFG_STRING_COUNT:     r_string_count     <= i_cfg_data[3:0];
                CFG_STRING_CHARS:     r_string_chars     <= i_cfg_data;
                CFG_REPORT_DESC_LEN:  r_report_desc_len  <= i_cfg_data[15:0];
                CFG_EP_ENABLE_MASK:   r_ep_mask          <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Device state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_addr_valid <= 1'b0;
            r_cur_cfg    <= '0;
            for (int e = 0; e < ENDPOINTS; e++) begin
                r_ep_cfg[e]  <= (e == 0) ? 2'b11 : 2'b00;
                r_ep_halt[e] <= 2'b00;
            end
        end else if (i_cmd.exec) begin
            r_addr       <= n_addr;
            r_addr_valid <= n_addr_valid;
            r_cur_cfg    <= n_cur_cfg;
            r_ep_cfg     <= n_ep_cfg;
            r_ep_halt    <= n_ep_halt;
        end
    end

    // Request capture and response register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_in_data;
        if (i_cmd.exec) r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

[sv/usb_standard_request_handler_top.sv]
// USB chapter 9 standard request handler, top level.
// Channels: input setup packet (i_in_valid / o_in_stall, struct i_in_data),
// output response (o_out_valid / i_out_stall, struct o_out_data), and a
// configuration write port (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
// that is always ready and takes effect at the edge of the transfer.
// A packet accepted at an edge is captured and then decoded in the EXEC state; its
// response is loaded into the output register once that register is free, and is
// valid from then on. No new packet is taken while a decode is pending;
// o_in_stall is high in the decode state.
// When the receiver stalls, the response holds in the output register; one more
// packet may be accepted, and its decode waits until the register is taken.
// Reset (synchronous, active low) clears the address, configuration value and
// halt bits, marks endpoint 0 configured, and loads the config register defaults.
// Depends on usrh_pkg, usrh_ctrl, usrh_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "usb_standard_request_handler_top_macros.svh"

module usb_standard_request_handler_top #(
    parameter int ENDPOINTS = usrh_pkg::ENDPOINTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  usrh_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output usrh_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import usrh_pkg::*;

    t_dp_cmd cmd;
    logic    cfg_we;

    // Config port never back-pressures
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Handshake sequencing
    usrh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Decode and device state
    usrh_dp #(
        .ENDPOINTS (ENDPOINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

    // Checks
    `USRH_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")
    `USRH_ASSERT_NOW(a_no_load_and_exec, 1'b1, !(cmd.load && cmd.exec), "load and decode together")
    `USRH_ASSERT_NOW(a_stall_is_empty, o_out_valid && o_out_data.action == ACT_STALL, o_out_data.send_length == 16'd0 && o_out_data.data_source == SRC_DEVICE, "stall response carries data")
    `USRH_ASSERT_NOW(a_cfg_event_ack, o_out_valid && o_out_data.configured_event, o_out_data.action == ACT_ZLP, "configured event without acknowledge")

endmodule
